// ----- src/gfd_pkg.sv -----
// Shared types and constants for the GF glyph run decoder.
package gfd_pkg;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EOC   = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;
   localparam logic [1:0] ST_ROW   = 2'd3;

   // GF opcodes.
   localparam logic [7:0] OP_PAINT1   = 8'd64;
   localparam logic [7:0] OP_PAINT3   = 8'd66;
   localparam logic [7:0] OP_BOC      = 8'd67;
   localparam logic [7:0] OP_BOC1     = 8'd68;
   localparam logic [7:0] OP_EOC      = 8'd69;
   localparam logic [7:0] OP_SKIP0    = 8'd70;
   localparam logic [7:0] OP_SKIP1    = 8'd71;
   localparam logic [7:0] OP_SKIP3    = 8'd73;
   localparam logic [7:0] OP_NEWROW0  = 8'd74;
   localparam logic [7:0] OP_NEWROW_L = 8'd238;
   localparam logic [7:0] OP_XXX1     = 8'd239;
   localparam logic [7:0] OP_XXX4     = 8'd242;
   localparam logic [7:0] OP_YYY      = 8'd243;
   localparam logic [7:0] OP_NOOP     = 8'd244;

   typedef enum logic [5:0] {
      PH_WAIT = 6'b000001,
      PH_BOC  = 6'b000010,
      PH_BOC1 = 6'b000100,
      PH_CMD  = 6'b001000,
      PH_NUM  = 6'b010000,
      PH_SKIP = 6'b100000
   } phase_type;

   // Request to clear the bitmap or paint a black run into it.
   typedef struct packed {
      logic       clear;   // clear every row (boc)
      logic       paint;   // OR a mask into one row
      logic [7:0] row;
      logic [63:0] mask;
   } bm_cmd_type;

endpackage

// ----- src/gf_glyph_run_decoder.sv -----
// Top level of the GF glyph run decoder.
//
// The block decodes one TeX GF glyph fed as a stream of bytes on the req_
// channel and keeps the raster in a bank of 64-bit row words. Each request
// word is either one glyph byte or a row read (req_tuser high); every request
// gives exactly one result word on the rsp_ channel carrying a status, the
// row (for a read) and the current box size and offsets.
// A byte is parsed in the cycle it is accepted: the parser state, the
// bitmap and the output register are updated at that edge, so the result
// word shows in the next cycle, and a new word can be taken every cycle
// unless the output stalls. A paint run becomes one masked OR into a row.
// The output register frees itself when taken, so req_tready stays high
// while rsp_ is empty or being taken in the same cycle; when the receiver
// stalls, the held result stays put and req_tready falls until it leaves.
// Reset clears the bitmap, the box and the parser, which then waits for
// boc or boc1; the bitmap is also cleared at every boc by dropping its
// per-row valid bits. Bad opcodes, oversized boxes and paints outside the
// box give status format error and return the parser to waiting for boc.
module gf_glyph_run_decoder #(
   parameter int MAX_W = 64,
   parameter int MAX_H = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // stream_byte [7:0], row_select [13:8], zero [15:14]
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // status[1:0] row_bits[65:2] glyph_width[72:66]
                                    // glyph_height[79:73] x_offset[111:80] y_offset[143:112]
);

   logic accept;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic is_read_ff;

   gfd_pkg::phase_type phase_ff, phase_in;
   logic [31:0] col_ff, col_in, row_ff, row_in;
   logic        black_ff, black_in;
   logic [31:0] min_c_ff, min_c_in, max_c_ff, max_c_in;
   logic [31:0] min_r_ff, min_r_in, max_r_ff, max_r_in;
   logic [7:0]  op_ff, op_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] left_ff, left_in;
   logic        err_ff, err_in;
   gfd_pkg::bm_cmd_type bm_cmd;
   logic [63:0] rd_data;

   logic [7:0]  b;
   logic [32:0] bw, bh;
   logic [32:0] nw, nh;
   logic [31:0] acc_sh;
   logic [4:0]  idx;
   logic        st_fail;
   logic [31:0] pd;
   logic        do_paint;

   assign b          = req_tdata[7:0];
   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   // Box size from current registers (33-bit signed difference plus one).
   assign bw = {max_c_ff[31], max_c_ff} - {min_c_ff[31], min_c_ff} + 33'd1;
   assign bh = {max_r_ff[31], max_r_ff} - {min_r_ff[31], min_r_ff} + 33'd1;
   assign acc_sh = {acc_ff[23:0], b};
   assign idx = 5'(32'd24 - left_ff);

   function automatic logic box_bad(input logic [32:0] w, input logic [32:0] h);
      box_bad = w[32] || ($signed(w) > 33'(MAX_W)) || h[32] || ($signed(h) > 33'(MAX_H));
   endfunction

   always_comb begin
      phase_in = phase_ff;
      col_in = col_ff; row_in = row_ff; black_in = black_ff;
      min_c_in = min_c_ff; max_c_in = max_c_ff;
      min_r_in = min_r_ff; max_r_in = max_r_ff;
      op_in = op_ff; acc_in = acc_ff; left_in = left_ff; err_in = err_ff;
      status_in = gfd_pkg::ST_OK;
      st_fail = 1'b0;
      pd = '0;
      do_paint = 1'b0;
      nw = bw; nh = bh;
      bm_cmd = '0;

      if (req_tuser) begin
         status_in = gfd_pkg::ST_ROW;
      end else begin
         unique case (phase_ff)
            gfd_pkg::PH_WAIT: begin
               if (b == gfd_pkg::OP_BOC || b == gfd_pkg::OP_BOC1) begin
                  bm_cmd.clear = 1'b1;
                  err_in = 1'b0;
                  acc_in = '0;
                  left_in = (b == gfd_pkg::OP_BOC) ? 32'd24 : 32'd5;
                  phase_in = (b == gfd_pkg::OP_BOC) ? gfd_pkg::PH_BOC : gfd_pkg::PH_BOC1;
               end else begin
                  st_fail = 1'b1;
               end
            end
            gfd_pkg::PH_BOC: begin
               acc_in = acc_sh;
               if (idx >= 5'd8 && idx[1:0] == 2'b11) begin
                  case (idx[4:2])
                     3'd2:    min_c_in = acc_sh;
                     3'd3:    max_c_in = acc_sh;
                     3'd4:    min_r_in = acc_sh;
                     default: max_r_in = acc_sh;
                  endcase
               end
               if (idx[1:0] == 2'b11) acc_in = '0;
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  nw = {max_c_in[31], max_c_in} - {min_c_in[31], min_c_in} + 33'd1;
                  nh = {max_r_in[31], max_r_in} - {min_r_in[31], min_r_in} + 33'd1;
                  if (box_bad(nw, nh)) st_fail = 1'b1;
                  else begin
                     col_in = '0; row_in = '0; black_in = 1'b0;
                     phase_in = gfd_pkg::PH_CMD;
                  end
               end
            end
            gfd_pkg::PH_BOC1: begin
               case (left_ff[2:0])
                  3'd4:    min_c_in = {24'd0, b};
                  3'd3:    max_c_in = {24'd0, b};
                  3'd2:    min_r_in = {24'd0, b};
                  3'd1:    max_r_in = {24'd0, b};
                  default: ;
               endcase
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  min_c_in = max_c_ff - min_c_ff;
                  min_r_in = max_r_in - min_r_ff;
                  nw = {max_c_ff[31], max_c_ff} - {min_c_in[31], min_c_in} + 33'd1;
                  nh = {max_r_in[31], max_r_in} - {min_r_in[31], min_r_in} + 33'd1;
                  if (box_bad(nw, nh)) st_fail = 1'b1;
                  else begin
                     col_in = '0; row_in = '0; black_in = 1'b0;
                     phase_in = gfd_pkg::PH_CMD;
                  end
               end
            end
            gfd_pkg::PH_CMD: begin
               if (b == 8'd0) begin
                  black_in = !black_ff;
               end else if (b < gfd_pkg::OP_PAINT1) begin
                  pd = {24'd0, b};
                  do_paint = 1'b1;
               end else if (b <= gfd_pkg::OP_PAINT3) begin
                  op_in = b; acc_in = '0; left_in = 32'(b - 8'd63);
                  phase_in = gfd_pkg::PH_NUM;
               end else if (b == gfd_pkg::OP_EOC) begin
                  phase_in = gfd_pkg::PH_WAIT;
                  status_in = gfd_pkg::ST_EOC;
               end else if (b == gfd_pkg::OP_SKIP0) begin
                  col_in = '0; row_in = row_ff + 32'd1; black_in = 1'b0;
               end else if (b >= gfd_pkg::OP_SKIP1 && b <= gfd_pkg::OP_SKIP3) begin
                  op_in = b; acc_in = '0; left_in = 32'(b - 8'd70);
                  phase_in = gfd_pkg::PH_NUM;
               end else if (b >= gfd_pkg::OP_NEWROW0 && b <= gfd_pkg::OP_NEWROW_L) begin
                  col_in = 32'(b - gfd_pkg::OP_NEWROW0);
                  row_in = row_ff + 32'd1; black_in = 1'b1;
               end else if (b >= gfd_pkg::OP_XXX1 && b <= gfd_pkg::OP_XXX4) begin
                  op_in = b; acc_in = '0; left_in = 32'(b - 8'd238);
                  phase_in = gfd_pkg::PH_NUM;
               end else if (b == gfd_pkg::OP_YYY) begin
                  left_in = 32'd4; phase_in = gfd_pkg::PH_SKIP;
               end else if (b == gfd_pkg::OP_NOOP) begin
                  status_in = gfd_pkg::ST_OK;
               end else begin
                  st_fail = 1'b1;
               end
            end
            gfd_pkg::PH_NUM: begin
               acc_in = acc_sh;
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  phase_in = gfd_pkg::PH_CMD;
                  if (op_ff >= gfd_pkg::OP_PAINT1 && op_ff <= gfd_pkg::OP_PAINT3) begin
                     pd = acc_sh;
                     do_paint = 1'b1;
                  end else if (op_ff >= gfd_pkg::OP_SKIP1 && op_ff <= gfd_pkg::OP_SKIP3) begin
                     col_in = '0; row_in = row_ff + acc_sh + 32'd1; black_in = 1'b0;
                  end else if (acc_sh != 32'd0) begin
                     left_in = acc_sh; phase_in = gfd_pkg::PH_SKIP;
                  end
               end
            end
            gfd_pkg::PH_SKIP: begin
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) phase_in = gfd_pkg::PH_CMD;
            end
            default: st_fail = 1'b1;
         endcase

         // One paint run: a bounds check and a masked OR into one row.
         if (do_paint) begin
            if (black_ff && pd != 32'd0) begin
               if ({1'b0, row_ff} >= bh && !bh[32] || bh[32] ||
                   {1'b0, col_ff} >= bw || {1'b0, pd} > bw - {1'b0, col_ff}) begin
                  st_fail = 1'b1;
               end else begin
                  bm_cmd.paint = 1'b1;
                  bm_cmd.row   = row_ff[7:0];
                  // The box is at most 64 wide here, so col + run <= 64; a run
                  // that reaches the right edge shifts the lower bound out to zero.
                  bm_cmd.mask  = (64'hFFFF_FFFF_FFFF_FFFF >> col_ff[6:0]) &
                                 ~(64'hFFFF_FFFF_FFFF_FFFF >> 7'(col_ff[6:0] + pd[6:0]));
               end
            end
            if (!st_fail) begin
               col_in = col_ff + pd;
               black_in = !black_ff;
            end
         end

         if (st_fail) begin
            err_in = 1'b1;
            phase_in = gfd_pkg::PH_WAIT;
            status_in = gfd_pkg::ST_ERROR;
         end
      end

      if (!accept) begin
         phase_in = phase_ff;
         col_in = col_ff; row_in = row_ff; black_in = black_ff;
         min_c_in = min_c_ff; max_c_in = max_c_ff;
         min_r_in = min_r_ff; max_r_in = max_r_ff;
         op_in = op_ff; acc_in = acc_ff; left_in = left_ff; err_in = err_ff;
         bm_cmd = '0;
      end
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   gfd_bitmap #(.MAX_H(MAX_H)) u_bitmap (
      .clock  (clock),
      .reset  (reset),
      .cmd    (bm_cmd),
      .rd_en  (accept && req_tuser),
      .rd_row (req_tdata[13:8]),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff <= gfd_pkg::PH_WAIT;
         col_ff <= '0; row_ff <= '0; black_ff <= 1'b0;
         min_c_ff <= '0; max_c_ff <= '0; min_r_ff <= '0; max_r_ff <= '0;
         op_ff <= '0; acc_ff <= '0; left_ff <= '0; err_ff <= 1'b0;
         status_ff <= gfd_pkg::ST_OK;
         is_read_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
         col_ff <= col_in; row_ff <= row_in; black_ff <= black_in;
         min_c_ff <= min_c_in; max_c_ff <= max_c_in;
         min_r_ff <= min_r_in; max_r_ff <= max_r_in;
         op_ff <= op_in; acc_ff <= acc_in; left_ff <= left_in; err_ff <= err_in;
         if (accept) begin
            status_ff <= status_in;
            is_read_ff <= req_tuser;
         end
      end
   end

   // Box fields come straight from the box registers, which only change
   // on an accepted word, so they match the held result.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata[1:0]     = status_ff;
   assign rsp_tdata[65:2]    = is_read_ff ? rd_data : 64'd0;
   assign rsp_tdata[72:66]   = bw[6:0];
   assign rsp_tdata[79:73]   = bh[6:0];
   assign rsp_tdata[111:80]  = 32'd0 - min_c_ff;
   assign rsp_tdata[143:112] = max_r_ff;

endmodule

// ----- src/gfd_bitmap.sv -----
// Bitmap row store with a single-pass paint port and a registered read port.
module gfd_bitmap #(
   parameter int MAX_H = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  gfd_pkg::bm_cmd_type cmd,
   input  logic                rd_en,
   input  logic [5:0]          rd_row,
   output logic [63:0]         rd_data
);

   localparam int DEPTH = (MAX_H < 64) ? MAX_H : 64;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // A row not painted since the last clear reads as zero, so a clear only
   // drops the per-row valid bits. The first paint of a row writes the whole
   // word; later paints set only the bits of their mask, so no read is needed.
   logic [63:0]      rows_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [63:0]      rd_data_ff;
   logic             wr_en;
   logic [IW-1:0]    wr_idx;
   logic [IW-1:0]    rd_idx;

   assign wr_en  = cmd.paint && !cmd.clear && (32'(cmd.row) < DEPTH);
   assign wr_idx = cmd.row[IW-1:0];
   assign rd_idx = rd_row[IW-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int j = 0; j < 64; j++) begin
            if (!valid_ff[wr_idx] || cmd.mask[j]) begin
               rows_ff[wr_idx][j] <= cmd.mask[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_data_ff <= '0;
      end else if (rd_en) begin
         if ((32'(rd_row) < DEPTH) && valid_ff[rd_idx]) begin
            rd_data_ff <= rows_ff[rd_idx];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/gfd_checker.sv -----
// Port-level assertions for the GF glyph run decoder, bound to the top level.
module gfd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata
);

   // Every accepted word yields a result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("missing result");

   // A row read always reports row status.
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> rsp_tdata[1:0] == gfd_pkg::ST_ROW)
      else $error("read without row status");

   // A byte result never carries row data.
   a_byte_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != gfd_pkg::ST_ROW |-> rsp_tdata[65:2] == 64'd0)
      else $error("row data on byte result");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind gf_glyph_run_decoder gfd_checker u_gfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// ----- verif/tb_gf_glyph_run_decoder.sv -----
// Self-checking testbench for the GF glyph run decoder: directed and random glyph streams.
`timescale 1ns / 100ps

module tb_gf_glyph_run_decoder;
   localparam logic [1:0] ST_OK       = gfd_pkg::ST_OK;
   localparam logic [1:0] ST_EOC      = gfd_pkg::ST_EOC;
   localparam logic [1:0] ST_ERROR    = gfd_pkg::ST_ERROR;
   localparam logic [1:0] ST_ROW      = gfd_pkg::ST_ROW;
   localparam logic [7:0] OP_PAINT1   = gfd_pkg::OP_PAINT1;
   localparam logic [7:0] OP_PAINT3   = gfd_pkg::OP_PAINT3;
   localparam logic [7:0] OP_BOC      = gfd_pkg::OP_BOC;
   localparam logic [7:0] OP_BOC1     = gfd_pkg::OP_BOC1;
   localparam logic [7:0] OP_EOC      = gfd_pkg::OP_EOC;
   localparam logic [7:0] OP_SKIP0    = gfd_pkg::OP_SKIP0;
   localparam logic [7:0] OP_SKIP1    = gfd_pkg::OP_SKIP1;
   localparam logic [7:0] OP_SKIP3    = gfd_pkg::OP_SKIP3;
   localparam logic [7:0] OP_NEWROW0  = gfd_pkg::OP_NEWROW0;
   localparam logic [7:0] OP_NEWROW_L = gfd_pkg::OP_NEWROW_L;
   localparam logic [7:0] OP_XXX1     = gfd_pkg::OP_XXX1;
   localparam logic [7:0] OP_XXX4     = gfd_pkg::OP_XXX4;
   localparam logic [7:0] OP_YYY      = gfd_pkg::OP_YYY;
   localparam logic [7:0] OP_NOOP     = gfd_pkg::OP_NOOP;

   // Opcodes that the package leaves unnamed.
   localparam logic [7:0] OP_PAINT0    = 8'd0;
   localparam logic [7:0] OP_PAINT_TOP = 8'd63;
   localparam logic [7:0] OP_PAINT2    = 8'd65;
   localparam logic [7:0] OP_BAD_LO    = 8'd245;
   localparam logic [7:0] OP_BAD_HI    = 8'd255;
   localparam int         BOX_W_LIMIT  = 64;
   localparam int         BOX_H_LIMIT  = 64;
   localparam int         STALL_LIMIT  = 20000;
   localparam int         N_ITEMS      = 1500;

   typedef enum logic [5:0] {
      GL_IDLE  = 6'b000001,
      GL_BOX24 = 6'b000010,
      GL_BOX5  = 6'b000100,
      GL_CMD   = 6'b001000,
      GL_ARG   = 6'b010000,
      GL_SKIP  = 6'b100000
   } glyph_phase_type;

   typedef struct packed {
      logic       is_read;
      logic [7:0] data_byte;
      logic [5:0] row_sel;
   } request_type;

   // Laid out as on rsp_tdata, first field in the highest bits.
   typedef struct packed {
      logic [31:0] y_off;
      logic [31:0] x_off;
      logic [6:0]  height;
      logic [6:0]  width;
      logic [63:0] row_bits;
      logic [1:0]  status;
   } answer_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;

   gf_glyph_run_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   request_type pending_words[$];
   answer_type  awaited_answers[$];
   int       error_count = 0;
   int       words_sent = 0;
   int       answers_seen = 0;
   bit       hold_sender = 0;

   // Mirror of the decoder state, kept by the monitor.
   logic [63:0]  raster[64];
   logic [31:0]  pen_col, pen_row, min_col, max_col, min_row, max_row;
   logic [31:0]  number, count_left;
   logic [7:0]   held_op;
   logic         pen_black;
   glyph_phase_type gphase;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint box_width();
      return longint'($signed(max_col)) - longint'($signed(min_col)) + 1;
   endfunction

   function automatic longint box_height();
      return longint'($signed(max_row)) - longint'($signed(min_row)) + 1;
   endfunction

   function automatic logic [1:0] abort_glyph();
      gphase = GL_IDLE;
      return ST_ERROR;
   endfunction

   function automatic logic [1:0] close_box();
      longint w, h;
      w = box_width();
      h = box_height();
      if (w < 0 || w > BOX_W_LIMIT || h < 0 || h > BOX_H_LIMIT) return abort_glyph();
      pen_col = 0;
      pen_row = 0;
      pen_black = 1'b0;
      gphase = GL_CMD;
      return ST_OK;
   endfunction

   // A black run of d pixels becomes one mask ORed into the current row.
   function automatic logic [1:0] paint_run(logic [31:0] d);
      longint w, h, c;
      logic [63:0] run;
      if (pen_black && d > 0) begin
         w = box_width();
         h = box_height();
         c = longint'(pen_col);
         if (longint'(pen_row) >= h || c >= w || longint'(d) > w - c) return abort_glyph();
         run = (d >= 64) ? '1 : ((64'd1 << d) - 64'd1);
         raster[pen_row[5:0]] |= run << (64 - c - longint'(d));
      end
      pen_col += d;
      pen_black ^= 1'b1;
      return ST_OK;
   endfunction

   function automatic void start_number(logic [7:0] op, int n);
      held_op = op;
      number = 0;
      count_left = n;
      gphase = GL_ARG;
   endfunction

   function automatic logic [1:0] finish_number();
      gphase = GL_CMD;
      if (held_op >= OP_PAINT1 && held_op <= OP_PAINT3) return paint_run(number);
      if (held_op >= OP_SKIP1 && held_op <= OP_SKIP3) begin
         pen_col = 0;
         pen_row += number + 1;
         pen_black = 1'b0;
         return ST_OK;
      end
      if (number != 0) begin
         count_left = number;
         gphase = GL_SKIP;
      end
      return ST_OK;
   endfunction

   function automatic logic [1:0] run_command(logic [7:0] b);
      if (b == OP_PAINT0) begin
         pen_black ^= 1'b1;
         return ST_OK;
      end
      if (b <= OP_PAINT_TOP) return paint_run(32'(b));
      if (b <= OP_PAINT3) begin
         start_number(b, int'(b - OP_PAINT_TOP));
         return ST_OK;
      end
      if (b == OP_EOC) begin
         gphase = GL_IDLE;
         return ST_EOC;
      end
      if (b == OP_SKIP0) begin
         pen_col = 0;
         pen_row += 1;
         pen_black = 1'b0;
         return ST_OK;
      end
      if (b >= OP_SKIP1 && b <= OP_SKIP3) begin
         start_number(b, int'(b - OP_SKIP0));
         return ST_OK;
      end
      if (b >= OP_NEWROW0 && b <= OP_NEWROW_L) begin
         pen_col = 32'(b - OP_NEWROW0);
         pen_row += 1;
         pen_black = 1'b1;
         return ST_OK;
      end
      if (b >= OP_XXX1 && b <= OP_XXX4) begin
         start_number(b, int'(b - (OP_XXX1 - 8'd1)));
         return ST_OK;
      end
      if (b == OP_YYY) begin
         count_left = 4;
         gphase = GL_SKIP;
         return ST_OK;
      end
      if (b == OP_NOOP) return ST_OK;
      return abort_glyph();
   endfunction

   function automatic logic [1:0] take_byte(logic [7:0] b);
      logic [31:0] idx;
      case (gphase)
         GL_IDLE: begin
            if (b == OP_BOC || b == OP_BOC1) begin
               foreach (raster[i]) raster[i] = '0;
               number = 0;
               count_left = (b == OP_BOC) ? 24 : 5;
               gphase = (b == OP_BOC) ? GL_BOX24 : GL_BOX5;
               return ST_OK;
            end
            return abort_glyph();
         end
         GL_BOX24: begin
            // Six big-endian words: character code, back pointer, then the box.
            idx = 24 - count_left;
            number = (number << 8) | 32'(b);
            if (idx >= 8 && idx[1:0] == 2'd3) begin
               case ((idx - 8) >> 2)
                  0: min_col = number;
                  1: max_col = number;
                  2: min_row = number;
                  default: max_row = number;
               endcase
            end
            if (idx[1:0] == 2'd3) number = 0;
            count_left -= 1;
            if (count_left == 0) return close_box();
            return ST_OK;
         end
         GL_BOX5: begin
            // Short form: code, then deltas and maxima, one byte each.
            idx = 5 - count_left;
            if (idx == 1) min_col = 32'(b);
            else if (idx == 2) max_col = 32'(b);
            else if (idx == 3) min_row = 32'(b);
            else if (idx == 4) max_row = 32'(b);
            count_left -= 1;
            if (count_left == 0) begin
               min_col = max_col - min_col;
               min_row = max_row - min_row;
               return close_box();
            end
            return ST_OK;
         end
         GL_CMD: return run_command(b);
         GL_ARG: begin
            number = (number << 8) | 32'(b);
            count_left -= 1;
            if (count_left == 0) return finish_number();
            return ST_OK;
         end
         default: begin
            count_left -= 1;
            if (count_left == 0) gphase = GL_CMD;
            return ST_OK;
         end
      endcase
   endfunction

   function automatic answer_type predict_answer(request_type r);
      answer_type a;
      a.row_bits = '0;
      if (r.is_read) begin
         a.status = ST_ROW;
         a.row_bits = raster[r.row_sel];
      end else begin
         a.status = take_byte(r.data_byte);
      end
      a.width  = 7'(box_width());
      a.height = 7'(box_height());
      a.x_off  = 32'd0 - min_col;
      a.y_off  = max_row;
      return a;
   endfunction

   // Stimulus helpers: queue one stream byte or one row read.
   task automatic put_byte(logic [7:0] b);
      request_type r;
      r.is_read = 1'b0;
      r.data_byte = b;
      r.row_sel = 6'($urandom);
      pending_words.push_back(r);
   endtask

   task automatic put_read(logic [5:0] s);
      request_type r;
      r.is_read = 1'b1;
      r.data_byte = 8'($urandom);
      r.row_sel = s;
      pending_words.push_back(r);
   endtask

   task automatic put_word32(int v);
      for (int k = 3; k >= 0; k--) put_byte(8'(v >> (8 * k)));
   endtask

   // A mostly well-formed glyph with random content, sometimes broken.
   task automatic put_glyph();
      int mc, w, mr, h, ncmd, kind, k;
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 70) : $urandom_range(0, 40);
      h = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 70) : $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) begin
         mc = int'($urandom_range(0, 40)) - 20;
         mr = int'($urandom_range(0, 40)) - 20;
         put_byte(OP_BOC);
         put_word32($urandom);
         put_word32(($urandom_range(0, 1) == 0) ? -1 : $urandom);
         put_word32(mc);
         put_word32(mc + w - 1);
         put_word32(mr);
         put_word32(mr + h - 1);
      end else begin
         put_byte(OP_BOC1);
         put_byte(8'($urandom));
         put_byte(8'((w == 0) ? 0 : w - 1));
         put_byte(8'($urandom));
         put_byte(8'(h - 1));
         put_byte(8'($urandom));
      end
      ncmd = $urandom_range(5, 40);
      for (int n = 0; n < ncmd; n++) begin
         kind = $urandom_range(0, 15);
         case (kind)
            0, 1, 2: put_byte(8'($urandom_range(1, 12)));
            3: put_byte(8'($urandom_range(13, 63)));
            4: put_byte(OP_PAINT0);
            5: begin
               k = $urandom_range(OP_PAINT1, OP_PAINT3);
               put_byte(8'(k));
               for (int j = OP_PAINT1; j < k; j++) put_byte(8'd0);
               put_byte(8'($urandom_range(0, 70)));
            end
            6: put_byte(OP_SKIP0);
            7: begin
               k = $urandom_range(OP_SKIP1, OP_SKIP3);
               put_byte(8'(k));
               for (int j = OP_SKIP1; j < k; j++) put_byte(8'd0);
               put_byte(8'($urandom_range(0, 3)));
            end
            8, 9: put_byte(8'(OP_NEWROW0 + $urandom_range(0, 20)));
            10: put_byte(8'($urandom_range(OP_NEWROW0, OP_NEWROW_L)));
            11: begin
               k = $urandom_range(OP_XXX1, OP_XXX4);
               put_byte(8'(k));
               for (int j = OP_XXX1; j < k; j++) put_byte(8'd0);
               w = $urandom_range(0, 3);
               put_byte(8'(w));
               for (int j = 0; j < w; j++) put_byte(8'($urandom));
            end
            12: begin
               put_byte(OP_YYY);
               repeat (4) put_byte(8'($urandom));
            end
            13: put_byte(OP_NOOP);
            default: put_read(6'($urandom));
         endcase
      end
      k = $urandom_range(0, 19);
      if (k == 0) put_byte(8'($urandom_range(OP_BAD_LO, OP_BAD_HI)));
      else if (k == 1) put_byte(OP_BOC1);
      else if (k != 2) put_byte(OP_EOC);
      repeat ($urandom_range(0, 4)) put_read(6'($urandom));
   endtask

   // Sender: offers the next queued word unless idling or held back.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && !hold_sender &&
             ((words_sent > 400 && words_sent < 700) || $urandom_range(0, 99) >= 37)) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_words[0].is_read;
            req_tdata <= {2'b00, pending_words[0].row_sel, pending_words[0].data_byte};
            void'(pending_words.pop_front());
            words_sent <= words_sent + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, a quiet stretch, and one long hold-off.
   int hold_off = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (!hold_done && answers_seen > 900) begin
         hold_done <= 1'b1;
         hold_off <= 150;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (answers_seen > 400 && answers_seen < 700) ||
                       ($urandom_range(0, 99) >= 37);
      end
   end

   // Monitor: predicts on every accepted request and checks every result.
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         foreach (raster[i]) raster[i] = '0;
         {pen_col, pen_row, min_col, max_col, min_row, max_row} = '0;
         {number, count_left, held_op, pen_black} = '0;
         gphase = GL_IDLE;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = answer_type'(rsp_tdata);
            answers_seen <= answers_seen + 1;
            if (awaited_answers.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               error_count++;
            end else begin
               want = awaited_answers.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                  error_count++;
               end
               if (got.row_bits !== want.row_bits) begin
                  $display("%0t: row_bits expected %h actual %h", $time,
                           want.row_bits, got.row_bits);
                  error_count++;
               end
               if (got.width !== want.width) begin
                  $display("%0t: glyph_width expected %0d actual %0d", $time,
                           want.width, got.width);
                  error_count++;
               end
               if (got.height !== want.height) begin
                  $display("%0t: glyph_height expected %0d actual %0d", $time,
                           want.height, got.height);
                  error_count++;
               end
               if (got.x_off !== want.x_off) begin
                  $display("%0t: x_offset expected %h actual %h", $time, want.x_off, got.x_off);
                  error_count++;
               end
               if (got.y_off !== want.y_off) begin
                  $display("%0t: y_offset expected %h actual %h", $time, want.y_off, got.y_off);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_answers.push_back(predict_answer({req_tuser, req_tdata[7:0],
                                                      req_tdata[13:8]}));
      end
   end

   // Watchdog: cycles in which neither side moves a word.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_gf_glyph_run_decoder: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reads after reset, a stray byte, a full-size box painted edge to edge.
      put_read(6'd0);
      put_read(6'd63);
      put_byte(OP_BAD_HI);
      put_byte(OP_BOC1);
      put_byte(8'd0);
      put_byte(8'd63);
      put_byte(8'd63);
      put_byte(8'd63);
      put_byte(8'd63);
      put_byte(OP_PAINT0);
      put_byte(OP_PAINT1);
      put_byte(8'd64);
      put_read(6'd0);
      put_byte(OP_SKIP0);
      put_byte(OP_PAINT_TOP);
      put_byte(8'd1);
      put_byte(OP_YYY);
      repeat (4) put_byte(8'hFF);
      put_byte(OP_NOOP);
      put_byte(OP_XXX1);
      put_byte(8'd1);
      put_byte(8'hFF);
      put_byte(OP_NEWROW_L);
      put_byte(8'd1);
      put_read(6'd1);
      put_byte(OP_EOC);

      // Sender pause: let the directed part drain completely.
      wait (pending_words.size() == 0 && !req_tvalid && awaited_answers.size() == 0);
      hold_sender = 1'b1;
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;

      while (pending_words.size() < N_ITEMS) begin
         if ($urandom_range(0, 99) < 85) put_glyph();
         else if ($urandom_range(0, 1) == 0) put_byte(8'($urandom));
         else put_read(6'($urandom));
      end

      wait (pending_words.size() == 0 && !req_tvalid && awaited_answers.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && awaited_answers.size() == 0) begin
         $display("tb_gf_glyph_run_decoder: clean");
      end else begin
         $display("tb_gf_glyph_run_decoder: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/gfd_pkg.sv
src/gfd_bitmap.sv
src/gf_glyph_run_decoder.sv
src/gfd_checker.sv
verif/tb_gf_glyph_run_decoder.sv
